@@ sv/seb_pkg.sv @@
// Shared widths, mode codes and status codes of the syntax element bit reader.
`default_nettype none
package seb_pkg;
   localparam int SEB_UNIT_BYTES = 4096;
   localparam int MODE_W  = 4;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int MAXV_W  = 32;
   localparam int VALUE_W = 64;
   localparam int STAT_W  = 2;

   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [STAT_W-1:0]  status_type;

   localparam mode_type SEB_MODE_NEW_UNIT   = 4'd0;
   localparam mode_type SEB_MODE_APPEND     = 4'd1;
   localparam mode_type SEB_MODE_U          = 4'd2;
   localparam mode_type SEB_MODE_UE         = 4'd3;
   localparam mode_type SEB_MODE_SE         = 4'd4;
   localparam mode_type SEB_MODE_LEB128     = 4'd5;
   localparam mode_type SEB_MODE_UVLC       = 4'd6;
   localparam mode_type SEB_MODE_NS         = 4'd7;
   localparam mode_type SEB_MODE_SU         = 4'd8;
   localparam mode_type SEB_MODE_MORE_DATA  = 4'd9;
   localparam mode_type SEB_MODE_BITS_AVAIL = 4'd10;

   localparam status_type SEB_ST_OK       = 2'd0;
   localparam status_type SEB_ST_PAST_END = 2'd1;
   localparam status_type SEB_ST_COUNT    = 2'd2;
   localparam status_type SEB_ST_FULL     = 2'd3;
endpackage
`default_nettype wire

@@ sv/seb_if.sv @@
// Request and response channel interfaces of the syntax element bit reader.
`default_nettype none
interface seb_req_if;
   import seb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [BYTE_W-1:0]    data_byte;
   logic [COUNT_W-1:0]   bit_len;
   logic [MAXV_W-1:0]    max_value;
   modport source (output valid, mode, data_byte, bit_len, max_value, input ready);
   modport sink   (input valid, mode, data_byte, bit_len, max_value, output ready);
endinterface

interface seb_rsp_if;
   import seb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   value;
   logic                 answer_flag;
   logic [STAT_W-1:0]    status;
   modport source (output valid, value, answer_flag, status, input ready);
   modport sink   (input valid, value, answer_flag, status, output ready);
endinterface
`default_nettype wire

@@ sv/seb_store.sv @@
// Byte store of one coded unit: one write port, one registered read port.
`default_nettype none
module seb_store #(
   parameter int UNIT_BYTES = seb_pkg::SEB_UNIT_BYTES,
   parameter int ADDR_W     = $clog2(UNIT_BYTES)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [ADDR_W-1:0]          wr_addr,
   input  wire logic [seb_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic      [seb_pkg::BYTE_W-1:0] rd_data
);
   import seb_pkg::*;

   logic [BYTE_W-1:0] store_mem [UNIT_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ sv/seb_core.sv @@
// Read sequencer: walks the byte store bit by bit and decodes syntax elements.
`default_nettype none
module seb_core #(
   parameter int UNIT_BYTES = seb_pkg::SEB_UNIT_BYTES,
   parameter int ADDR_W     = $clog2(UNIT_BYTES),
   parameter int LEN_W      = ADDR_W + 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       skip_emulation,
   seb_req_if.sink                         req_bus,
   seb_rsp_if.source                       rsp_bus,
   output logic                            wr_en,
   output logic      [ADDR_W-1:0]          wr_addr,
   output logic      [seb_pkg::BYTE_W-1:0] wr_data,
   output logic                            rd_en,
   output logic      [ADDR_W-1:0]          rd_addr,
   input  wire logic [seb_pkg::BYTE_W-1:0] rd_data
);
   import seb_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_TAKE = 4'd2, S_ADV = 4'd3,
      S_ADV2 = 4'd4, S_FIN = 4'd5, S_MAP = 4'd6, S_SCAN = 4'd7, S_SCAN_CHK = 4'd8,
      S_RESP = 4'd9;
   localparam logic [1:0] PH_ZERO = 2'd0, PH_BITS = 2'd1, PH_EXTRA = 2'd2;
   localparam int POS_W = LEN_W + 4;

   logic [3:0]         st_ff, st_in;
   logic [1:0]         ph_ff, ph_in;
   mode_type           mode_ff, mode_in;
   logic [BYTE_W-1:0]  dbyte_ff, dbyte_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [MAXV_W-1:0]  maxv_ff, maxv_in;
   logic [5:0]         w_ff, w_in;
   logic [MAXV_W-1:0]  m_ff, m_in;
   logic [LEN_W-1:0]   len_ff, len_in, bpos_ff, bpos_in, wbyte_ff, wbyte_in;
   logic [3:0]         bit_ff, bit_in, wbit_ff, wbit_in;
   logic [1:0]         run_ff, run_in, wrun_ff, wrun_in;
   logic [COUNT_W-1:0] rem_ff, rem_in, zc_ff, zc_in;
   logic [2:0]         grp_ff, grp_in;
   logic [VALUE_W-1:0] acc_ff, acc_in, val_ff, val_in;
   logic               flag_ff, flag_in;
   status_type         stat_ff, stat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_flag_ff, rsp_flag_in;
   status_type         rsp_stat_ff, rsp_stat_in;

   logic               cur_bit;
   logic [VALUE_W-1:0] acc_nx;
   logic [LEN_W-1:0]   wbyte_nx;
   logic [5:0]         enc_w;
   logic [5:0]         nm1;
   logic [POS_W-1:0]   pos_need;
   logic [POS_W-1:0]   pos_total;
   logic [3:0]         bit_p1;
   logic               fin_ok;
   logic               is_read;

   assign req_bus.ready     = (st_ff == S_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.value     = rsp_value_ff;
   assign rsp_bus.answer_flag = rsp_flag_ff;
   assign rsp_bus.status    = rsp_stat_ff;

   always_comb begin
      enc_w = 6'd0;
      for (int i = 0; i < MAXV_W; i++) begin
         if (req_bus.max_value[i]) begin
            enc_w = 6'(i + 1);
         end
      end
   end

   assign cur_bit  = rd_data[3'(3'd7 - wbit_ff[2:0])];
   assign acc_nx   = {acc_ff[VALUE_W-2:0], cur_bit};
   assign wbyte_nx = wbyte_ff + LEN_W'(1);
   assign nm1      = 6'(n_ff - 7'd1);
   assign bit_p1   = bit_ff + 4'd1;
   assign pos_need = POS_W'({bpos_ff, 3'b000}) + POS_W'(bit_ff) + POS_W'(n_ff);
   assign pos_total = POS_W'({len_ff, 3'b000});
   assign is_read  = (mode_ff == SEB_MODE_U) || (mode_ff == SEB_MODE_UE) ||
                     (mode_ff == SEB_MODE_SE) || (mode_ff == SEB_MODE_LEB128) ||
                     (mode_ff == SEB_MODE_UVLC) || (mode_ff == SEB_MODE_NS) ||
                     (mode_ff == SEB_MODE_SU);

   always_comb begin
      st_in = st_ff;   ph_in = ph_ff;   mode_in = mode_ff;   dbyte_in = dbyte_ff;
      n_in = n_ff;     maxv_in = maxv_ff;   w_in = w_ff;     m_in = m_ff;
      len_in = len_ff; bpos_in = bpos_ff;   wbyte_in = wbyte_ff;
      bit_in = bit_ff; wbit_in = wbit_ff;   run_in = run_ff; wrun_in = wrun_ff;
      rem_in = rem_ff; zc_in = zc_ff;   grp_in = grp_ff;
      acc_in = acc_ff; val_in = val_ff; flag_in = flag_ff; stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;  rsp_flag_in = rsp_flag_ff;  rsp_stat_in = rsp_stat_ff;
      rd_en = 1'b0;
      rd_addr = wbyte_ff[ADDR_W-1:0];
      wr_en = 1'b0;
      wr_addr = len_ff[ADDR_W-1:0];
      wr_data = dbyte_ff;
      fin_ok = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               mode_in = req_bus.mode;   dbyte_in = req_bus.data_byte;
               n_in = req_bus.bit_len;   maxv_in = req_bus.max_value;
               w_in = enc_w;
               wbyte_in = bpos_ff;  wbit_in = bit_ff;  wrun_in = run_ff;
               acc_in = '0;  val_in = '0;  flag_in = 1'b0;  stat_in = SEB_ST_OK;
               zc_in = '0;   grp_in = '0;  ph_in = PH_BITS;
               rd_addr = bpos_ff[ADDR_W-1:0];
               st_in = S_RESP;
               case (req_bus.mode)
                  SEB_MODE_U, SEB_MODE_SU: begin
                     rem_in = req_bus.bit_len;
                     if (req_bus.bit_len > 7'd64) begin
                        stat_in = SEB_ST_COUNT;
                     end else if (req_bus.bit_len != 7'd0) begin
                        rd_en = 1'b1;
                        st_in = S_LOAD;
                     end
                  end
                  SEB_MODE_UE, SEB_MODE_SE, SEB_MODE_UVLC: begin
                     ph_in = PH_ZERO;
                     rd_en = 1'b1;
                     st_in = S_LOAD;
                  end
                  SEB_MODE_LEB128: begin
                     rem_in = 7'd8;
                     rd_en = 1'b1;
                     st_in = S_LOAD;
                  end
                  SEB_MODE_NS: begin
                     rem_in = 7'(enc_w - 6'd1);
                     if (req_bus.max_value > 32'd1) begin
                        rd_en = 1'b1;
                        st_in = S_LOAD;
                     end
                  end
                  SEB_MODE_MORE_DATA: begin
                     // The scan starts one bit after the next unread bit.
                     wbyte_in = bpos_ff + LEN_W'(bit_p1[3]);
                     wbit_in = {1'b0, bit_p1[2:0]};
                     st_in = S_SCAN;
                  end
                  default: begin
                     st_in = S_RESP;
                  end
               endcase
            end
         end
         S_LOAD: begin
            m_in = 32'((33'd1 << w_ff) - {1'b0, maxv_ff});
            st_in = S_TAKE;
         end
         S_TAKE: begin
            if (wbit_ff < 4'd8) begin
               if (wbyte_ff >= len_ff) begin
                  stat_in = SEB_ST_PAST_END;
                  st_in = S_RESP;
               end else begin
                  wbit_in = wbit_ff + 4'd1;
                  case (ph_ff)
                     PH_ZERO: begin
                        if (cur_bit) begin
                           acc_in = '0;
                           if (mode_ff == SEB_MODE_UVLC) begin
                              if (zc_ff >= 7'd32) begin
                                 val_in = 64'hFFFF_FFFF;
                                 st_in = S_RESP;
                              end else if (zc_ff == 7'd0) begin
                                 st_in = S_FIN;
                              end else begin
                                 rem_in = zc_ff;
                                 ph_in = PH_BITS;
                              end
                           end else if (zc_ff > 7'd63) begin
                              stat_in = SEB_ST_COUNT;
                              st_in = S_RESP;
                           end else if (zc_ff == 7'd0) begin
                              st_in = S_FIN;
                           end else begin
                              rem_in = zc_ff;
                              ph_in = PH_BITS;
                           end
                        end else if (zc_ff < 7'd64) begin
                           zc_in = zc_ff + 7'd1;
                        end
                     end
                     PH_BITS: begin
                        acc_in = acc_nx;
                        rem_in = rem_ff - 7'd1;
                        if (rem_ff == 7'd1) begin
                           if (mode_ff == SEB_MODE_LEB128) begin
                              val_in = val_ff |
                                 (VALUE_W'(acc_nx[6:0]) << (6'(grp_ff) * 6'd7));
                              acc_in = '0;
                              rem_in = 7'd8;
                              grp_in = grp_ff + 3'd1;
                              if (!acc_nx[7] || grp_ff == 3'd7) begin
                                 st_in = S_RESP;
                              end
                           end else if (mode_ff == SEB_MODE_NS) begin
                              if (acc_nx < VALUE_W'(m_ff)) begin
                                 val_in = acc_nx;
                                 st_in = S_RESP;
                              end else begin
                                 ph_in = PH_EXTRA;
                              end
                           end else begin
                              st_in = S_FIN;
                           end
                        end
                     end
                     default: begin
                        val_in = acc_nx - VALUE_W'(m_ff);
                        st_in = S_RESP;
                     end
                  endcase
               end
            end else begin
               // Leave the used-up byte and fetch the next one.
               if (rd_data == 8'd0 && wrun_ff != 2'd3) begin
                  wrun_in = wrun_ff + 2'd1;
               end
               wbit_in = 4'd0;
               wbyte_in = wbyte_nx;
               if (wbyte_nx >= len_ff) begin
                  stat_in = SEB_ST_PAST_END;
                  st_in = S_RESP;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = wbyte_nx[ADDR_W-1:0];
                  st_in = S_ADV;
               end
            end
         end
         S_ADV: begin
            st_in = S_TAKE;
            if (skip_emulation && wrun_ff == 2'd2 && rd_data == 8'd3) begin
               wbyte_in = wbyte_nx;
               wrun_in = 2'd0;
               if (wbyte_nx >= len_ff) begin
                  stat_in = SEB_ST_PAST_END;
                  st_in = S_RESP;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = wbyte_nx[ADDR_W-1:0];
                  st_in = S_ADV2;
               end
            end else if (skip_emulation && rd_data != 8'd0) begin
               wrun_in = 2'd0;
            end
         end
         S_ADV2: begin
            st_in = S_TAKE;
         end
         S_FIN: begin
            st_in = S_RESP;
            case (mode_ff)
               SEB_MODE_U: begin
                  val_in = acc_ff;
               end
               SEB_MODE_SU: begin
                  if (n_ff < 7'd64 && acc_ff[nm1]) begin
                     val_in = acc_ff | (~64'd0 << n_ff[5:0]);
                  end else begin
                     val_in = acc_ff;
                  end
               end
               default: begin
                  val_in = acc_ff + ~(~64'd0 << zc_ff[5:0]);
                  if (mode_ff == SEB_MODE_SE) begin
                     st_in = S_MAP;
                  end
               end
            endcase
         end
         S_MAP: begin
            val_in = val_ff[0] ? ((val_ff >> 1) + 64'd1) : (64'd0 - (val_ff >> 1));
            st_in = S_RESP;
         end
         S_SCAN: begin
            if (wbyte_ff >= len_ff) begin
               st_in = S_RESP;
            end else begin
               rd_en = 1'b1;
               st_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (8'(rd_data << wbit_ff[2:0]) != 8'd0) begin
               flag_in = 1'b1;
               st_in = S_RESP;
            end else begin
               wbyte_in = wbyte_nx;
               wbit_in = 4'd0;
               st_in = S_SCAN;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               fin_ok = 1'b1;
               st_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_stat_in = stat_ff;
               rsp_flag_in = 1'b0;
               rsp_value_in = '0;
               case (mode_ff)
                  SEB_MODE_NEW_UNIT: begin
                     len_in = '0;  bpos_in = '0;  bit_in = '0;  run_in = '0;
                  end
                  SEB_MODE_APPEND: begin
                     if (len_ff >= LEN_W'(UNIT_BYTES)) begin
                        rsp_stat_in = SEB_ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  SEB_MODE_MORE_DATA: begin
                     rsp_flag_in = flag_ff;
                  end
                  SEB_MODE_BITS_AVAIL: begin
                     rsp_flag_in = (pos_need <= pos_total);
                  end
                  default: begin
                     if (is_read && stat_ff == SEB_ST_OK) begin
                        bpos_in = wbyte_ff;
                        bit_in = wbit_ff;
                        run_in = wrun_ff;
                        rsp_value_in = val_ff;
                     end
                  end
               endcase
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         len_ff <= '0;
         bpos_ff <= '0;
         bit_ff <= '0;
         run_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         len_ff <= len_in;
         bpos_ff <= bpos_in;
         bit_ff <= bit_in;
         run_ff <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff <= ph_in;       mode_ff <= mode_in;   dbyte_ff <= dbyte_in;
      n_ff <= n_in;         maxv_ff <= maxv_in;   w_ff <= w_in;   m_ff <= m_in;
      wbyte_ff <= wbyte_in; wbit_ff <= wbit_in;   wrun_ff <= wrun_in;
      rem_ff <= rem_in;     zc_ff <= zc_in;       grp_ff <= grp_in;
      acc_ff <= acc_in;     val_ff <= val_in;     flag_ff <= flag_in;
      stat_ff <= stat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // The committed read position never runs past the end of the unit.
   a_pos_in_unit: assert property (@(posedge clock) disable iff (reset)
      bpos_ff <= len_ff)
      else $error("read position beyond unit length");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= 4'd8)
      else $error("bit position out of range");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (len_ff < LEN_W'(UNIT_BYTES)) && (st_ff == S_RESP))
      else $error("store written while full or outside result step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (st_ff != S_IDLE))
      else $error("sequencer idle right after accepting a word");

   // Positions change only when a result is handed to the output register.
   a_commit_only_at_result: assert property (@(posedge clock) disable iff (reset)
      !fin_ok |=> $stable(bpos_ff) && $stable(len_ff))
      else $error("position changed outside result step");
endmodule
`default_nettype wire

@@ sv/syntax_element_bit_reader_top.sv @@
// Top level of the syntax element bit reader: configuration register, sequencer and store.
// Load a unit with one new-unit word followed by append words, then send read words; every
// word returns exactly one response word. New-unit, append, bits-available and unused modes
// go from idle straight to the result step. A read element passes through setup and result
// states, one cycle per bit read, and an advance state at each byte boundary crossed, since
// the store has a single registered read port (plus a second advance state when an emulation
// prevention byte is skipped). The more-data query goes through a scan and a check state for
// each byte it scans, up to the rest of the unit. The store needs no clearing after reset. A
// new request word is taken while the previous response still waits on the output register.
`default_nettype none
module syntax_element_bit_reader_top #(
   parameter int UNIT_BYTES = seb_pkg::SEB_UNIT_BYTES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   seb_req_if.sink    req_bus,
   seb_rsp_if.source  rsp_bus,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data
);
   import seb_pkg::*;

   localparam int ADDR_W = $clog2(UNIT_BYTES);

   logic               skip_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [BYTE_W-1:0]  wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
      end else if (csr_write_enable) begin
         skip_ff <= csr_write_data;
      end
   end

   seb_core #(
      .UNIT_BYTES (UNIT_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .skip_emulation (skip_ff),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   seb_store #(
      .UNIT_BYTES (UNIT_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire

@@ dv/syntax_element_bit_reader_top_tb.sv @@
// Self-checking testbench for the syntax element bit reader top level.
`default_nettype none
module syntax_element_bit_reader_top_tb;
   import seb_pkg::*;

   localparam int MAX_CYCLES = 4000000;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               answer_flag;
      status_type         status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;

   seb_req_if req_bus ();
   seb_rsp_if rsp_bus ();

   syntax_element_bit_reader_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // Predictor state.
   logic [7:0]  unit_mem [SEB_UNIT_BYTES];
   int unsigned unit_len, byte_pos, bit_pos, zero_run;
   logic        skip_on;

   answer_type  expected_answers [$];
   int          errors = 0;
   int          answers_seen = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_requests = 0;
   int          hold_taken = 0;
   int          hold_left = 0;

   function automatic bit step_byte();
      if (byte_pos < unit_len && unit_mem[byte_pos] == 8'h00 && zero_run < 3)
         zero_run++;
      bit_pos = 0;
      byte_pos++;
      if (byte_pos >= unit_len) return 1'b0;
      if (skip_on) begin
         if (zero_run == 2 && unit_mem[byte_pos] == 8'h03) begin
            byte_pos++;
            if (byte_pos >= unit_len) return 1'b0;
            zero_run = 0;
         end else if (unit_mem[byte_pos] != 8'h00) begin
            zero_run = 0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit pull_bit(output logic [63:0] b);
      b = 0;
      if (bit_pos >= 8)
         if (!step_byte()) return 1'b0;
      if (byte_pos >= unit_len) return 1'b0;
      b = 64'(unit_mem[byte_pos][7 - bit_pos]);
      bit_pos++;
      return 1'b1;
   endfunction

   function automatic bit pull_bits(input int unsigned n, output logic [63:0] v);
      logic [63:0] b;
      v = 0;
      for (int unsigned i = 0; i < n; i++) begin
         if (!pull_bit(b)) return 1'b0;
         v = (v << 1) | b;
      end
      return 1'b1;
   endfunction

   function automatic bit pull_zero_run(output int unsigned z);
      logic [63:0] b;
      z = 0;
      forever begin
         if (!pull_bit(b)) return 1'b0;
         if (b[0]) return 1'b1;
         z++;
      end
   endfunction

   function automatic answer_type predict_answer(mode_type mode, logic [7:0] dbyte,
                                                 logic [6:0] n, logic [31:0] maxv);
      int unsigned s_byte, s_bit, s_run, z, w;
      logic [63:0] v, b, value, m, p, total, left;
      logic [31:0] x;
      logic flag;
      status_type st;
      bit ok;
      answer_type r;
      s_byte = byte_pos; s_bit = bit_pos; s_run = zero_run;
      value = 0; flag = 0; st = SEB_ST_OK; ok = 1; v = 0; b = 0; z = 0;
      case (mode)
         SEB_MODE_NEW_UNIT: begin
            unit_len = 0; byte_pos = 0; bit_pos = 0; zero_run = 0;
         end
         SEB_MODE_APPEND: begin
            if (unit_len >= SEB_UNIT_BYTES) st = SEB_ST_FULL;
            else begin
               unit_mem[unit_len] = dbyte;
               unit_len++;
            end
         end
         SEB_MODE_U, SEB_MODE_SU: begin
            if (n > 64) st = SEB_ST_COUNT;
            else if (n > 0) begin
               ok = pull_bits(n, v);
               if (ok && mode == SEB_MODE_SU && n < 64 && v[n-1])
                  v |= ~64'd0 << n;
               value = v;
            end
         end
         SEB_MODE_UE, SEB_MODE_SE: begin
            ok = pull_zero_run(z);
            if (ok && z > 63) st = SEB_ST_COUNT;
            else if (ok) begin
               ok = pull_bits(z, v);
               v = v + ((64'd1 << z) - 64'd1);
               if (mode == SEB_MODE_SE)
                  v = v[0] ? (v >> 1) + 64'd1 : 64'd0 - (v >> 1);
               value = v;
            end
         end
         SEB_MODE_LEB128: begin
            for (int i = 0; i < 8; i++) begin
               ok = pull_bits(8, v);
               if (!ok) break;
               value |= (v & 64'h7f) << (i * 7);
               if (!v[7]) break;
            end
         end
         SEB_MODE_UVLC: begin
            ok = pull_zero_run(z);
            if (ok) begin
               if (z >= 32) value = (64'd1 << 32) - 64'd1;
               else begin
                  ok = pull_bits(z, v);
                  value = v + (64'd1 << z) - 64'd1;
               end
            end
         end
         SEB_MODE_NS: begin
            if (maxv > 1) begin
               w = 0; x = maxv;
               while (x != 0) begin x >>= 1; w++; end
               m = (64'd1 << w) - 64'(maxv);
               ok = pull_bits(w - 1, v);
               if (ok) begin
                  if (v < m) value = v;
                  else begin
                     ok = pull_bit(b);
                     value = (v << 1) - m + b;
                  end
               end
            end
         end
         SEB_MODE_MORE_DATA: begin
            p = 64'(byte_pos) * 8 + bit_pos + 1;
            total = 64'(unit_len) * 8;
            while (p < total && !flag) begin
               if ((p >> 3) < unit_len && ((unit_mem[p >> 3] << p[2:0]) & 8'hff) != 0)
                  flag = 1;
               p = ((p >> 3) + 1) << 3;
            end
         end
         SEB_MODE_BITS_AVAIL: begin
            p = 64'(byte_pos) * 8 + bit_pos;
            total = 64'(unit_len) * 8;
            left = (p > total) ? 64'd0 : total - p;
            flag = (64'(n) <= left);
         end
         default: ;
      endcase
      if (!ok) st = SEB_ST_PAST_END;
      if (st == SEB_ST_PAST_END || st == SEB_ST_COUNT) begin
         byte_pos = s_byte; bit_pos = s_bit; zero_run = s_run;
         value = 0; flag = 0;
      end
      r.value = value; r.answer_flag = flag; r.status = st;
      return r;
   endfunction

   // Sends one word and records its expected answer on acceptance.
   task automatic send_word(mode_type mode, logic [7:0] dbyte = 0, logic [6:0] n = 0,
                            logic [31:0] maxv = 0);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.data_byte <= dbyte;
      req_bus.bit_len   <= n;
      req_bus.max_value <= maxv;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_answers.push_back(predict_answer(mode, dbyte, n, maxv));
   endtask

   // Stops sending and waits until every expected answer has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_skip(logic val);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      skip_on = val;
   endtask

   task automatic load_unit(int len, int style);
      send_word(SEB_MODE_NEW_UNIT);
      for (int i = 0; i < len; i++) begin
         logic [7:0] d;
         case (style)
            0: d = 8'($urandom);
            1: d = ($urandom_range(3) == 0) ? 8'h03 :
                   (($urandom_range(1) == 0) ? 8'h00 : 8'($urandom));
            default: d = ($urandom_range(4) == 0) ? 8'($urandom) : 8'h00;
         endcase
         send_word(SEB_MODE_APPEND, d);
      end
   endtask

   task automatic random_read();
      mode_type md;
      logic [6:0] n;
      logic [31:0] mv;
      md = mode_type'($urandom_range(SEB_MODE_BITS_AVAIL, SEB_MODE_U));
      if ($urandom_range(40) == 0) md = mode_type'($urandom_range(15, 11));
      n = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(16));
      mv = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(300));
      send_word(md, 8'($urandom), n, mv);
   endtask

   task automatic test_directed();
      load_unit(0, 0);
      send_word(SEB_MODE_U, 0, 1);
      send_word(SEB_MODE_MORE_DATA);
      send_word(SEB_MODE_BITS_AVAIL, 0, 0);
      send_word(SEB_MODE_NEW_UNIT);
      send_word(SEB_MODE_APPEND, 8'h00); send_word(SEB_MODE_APPEND, 8'h00);
      send_word(SEB_MODE_APPEND, 8'h03); send_word(SEB_MODE_APPEND, 8'h81);
      for (int i = 0; i < 10; i++) send_word(SEB_MODE_APPEND, 8'hff);
      send_word(SEB_MODE_U, 0, 0);
      send_word(SEB_MODE_U, 0, 7'd65);
      send_word(SEB_MODE_SU, 0, 7'd127);
      send_word(SEB_MODE_UVLC);
      send_word(SEB_MODE_NS, 0, 0, 32'd1);
      send_word(SEB_MODE_NS, 0, 0, 32'hffffffff);
      send_word(SEB_MODE_SU, 0, 7'd64);
      send_word(SEB_MODE_UE);
      send_word(SEB_MODE_SE);
      send_word(SEB_MODE_LEB128);
      send_word(SEB_MODE_MORE_DATA);
      send_word(SEB_MODE_BITS_AVAIL, 0, 7'd127);
      send_word(mode_type'(4'd15), 8'hff, 7'h7f, 32'hffffffff);
   endtask

   task automatic test_random(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         int len;
         len = $urandom_range(24, 1);
         load_unit(len, $urandom_range(2));
         sent += len + 1;
         repeat ($urandom_range(14, 2)) begin
            random_read();
            sent++;
         end
      end
   endtask

   // The receiver stalls for a long stretch while words keep coming.
   task automatic test_backpressure();
      drain();
      hold_requests++;
      load_unit(8, 0);
      repeat (20) random_read();
      drain();
   endtask

   initial begin
      req_bus.valid = 1'b0; req_bus.mode = 0; req_bus.data_byte = 0;
      req_bus.bit_len = 0; req_bus.max_value = 0;
      unit_len = 0; byte_pos = 0; bit_pos = 0; zero_run = 0; skip_on = 1'b1;
      foreach (unit_mem[i]) unit_mem[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_skip(1'b0);
      test_directed();
      write_skip(1'b1);
      send_idle_pct = 13; recv_idle_pct = 66;
      test_random(500);
      write_skip(1'b0);
      send_idle_pct = 66; recv_idle_pct = 13;
      test_random(500);
      write_skip(1'b1);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(500);
      test_backpressure();
      drain();
      $display("Covered directed cases, both emulation settings, random units, a long stall");
      $display("and idle patterns on both sides, %0d answers checked", answers_seen);
      if (errors == 0)
         $display("syntax_element_bit_reader_top: match");
      else
         $display("syntax_element_bit_reader_top: mismatch");
      $finish;
   end

   // Receiver readiness, including one long hold-off.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_requests) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 400;
         hold_taken <= hold_requests;
      end else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Answer checker.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen <= answers_seen + 1;
         if (expected_answers.size() == 0) begin
            errors <= errors + 1;
            $display("%0t: unexpected word value=%h flag=%b status=%0d", $time,
                     rsp_bus.value, rsp_bus.answer_flag, rsp_bus.status);
         end else begin
            e = expected_answers.pop_front();
            if (e.value !== rsp_bus.value || e.answer_flag !== rsp_bus.answer_flag ||
                e.status !== rsp_bus.status) begin
               errors <= errors + 1;
               $display("%0t: expected value=%h flag=%b status=%0d,", $time,
                        e.value, e.answer_flag, e.status);
               $display("   got value=%h flag=%b status=%0d",
                        rsp_bus.value, rsp_bus.answer_flag, rsp_bus.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("syntax_element_bit_reader_top: mismatch");
         $finish;
      end
   end
endmodule
`default_nettype wire
